// ===== src/mdea_pkg.sv =====
// shared types, constants and helpers for the diagonal edit aligner
package mdea_pkg;

  localparam int MaxLen      = 256;
  localparam int MaxD        = 32;
  localparam int GapDiscount = 8;
  localparam int RowOff      = MaxD + 1;

  localparam int SymW  = 4;
  localparam int LenW  = $clog2(MaxLen) + 1;
  localparam int AddrW = $clog2(MaxLen);
  localparam int DistW = $clog2(MaxD) + 1;
  localparam int XW    = 10;
  localparam int KW    = 10;
  localparam int YW    = 12;
  localparam int IdxW  = 9;
  localparam int RowDepth = 2 * (2 ** IdxW);

  // item kinds
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // end modes
  typedef enum logic [2:0] {
    AM_EQUAL    = 3'd0,
    AM_A_PREFIX = 3'd1,
    AM_B_PREFIX = 3'd2,
    AM_EITHER   = 3'd3,
    AM_PRIMER   = 3'd4,
    AM_OVERLAP  = 3'd5
  } amode_e;

  // configuration register indexes
  typedef enum logic {
    REG_ALIGN_MODE = 1'b0,
    REG_MAX_DIST   = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_K,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_SN_RD,
    ST_SN_CMP,
    ST_END,
    ST_RES
  } state_e;

  // one queued transaction
  typedef struct packed {
    op_e             op;
    logic [SymW-1:0] sym;
  } item_t;

  // highest diagonal searched in row d
  function automatic logic signed [KW-1:0] upper_diag(amode_e m, logic [DistW-1:0] d);
    logic signed [KW-1:0] dd;
    dd = $signed(KW'(d));
    case (m)
      AM_OVERLAP: upper_diag = KW'(GapDiscount * int'(d) + GapDiscount - 1);
      AM_PRIMER:  upper_diag = dd + KW'(2);
      default:    upper_diag = dd;
    endcase
  endfunction

endpackage

// ===== src/myers_diagonal_edit_aligner.sv =====
// top level of the diagonal edit-distance aligner
//
// usage: the slave stream takes one transaction per item; tuser carries the
// kind (load a, load b, start, code 3 is ignored) and tdata the 4-bit base
// bitmap. loads are taken one per cycle through a two-entry queue while the sequencer
// is idle, and each store holds at most 256 symbols (extra symbols are dropped).
// a start transaction runs the furthest-reaching diagonal search and yields
// one master transaction: found, distance, end position in b, end in a.
// each diagonal after row 0 passes through setup and the three previous-row
// reads from the one-write one-read row memory, then sets the first snake
// address, reads and compares a symbol pair for each matched symbol of the snake,
// compares once more when the snake stops on a mismatch, and ends with a row
// write; row 0 skips the reads. the search time depends on the data, and the
// result then passes through the result state into the output register.
// after the result both sequence lengths return to zero.
// the config port writes align_mode (index 0) and max_distance (index 1); the user
// must do so only while the block is idle, the block does not enforce it. reset
// clears lengths, sets equal mode and a limit of 32. when the master side stalls,
// the result waits in its register and the queue keeps taking loads until it fills.
module myers_diagonal_edit_aligner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // item kind
  input  logic [7:0]  s_axis_tdata,   // symbol[3:0], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // found, distance[6], x_end[9], y_end[9], zero fill
);

  logic                           item_valid, item_ready;
  mdea_pkg::item_t                item;
  logic                           found;
  logic [mdea_pkg::DistW-1:0]     distance;
  logic [8:0]                     x_end, y_end;

  mdea_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready),
    .s_tuser_i(s_axis_tuser), .s_tdata_i(s_axis_tdata[mdea_pkg::SymW-1:0]),
    .item_valid_o(item_valid), .item_ready_i(item_ready), .item_o(item)
  );

  mdea_back u_back (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_valid_i(item_valid), .item_ready_o(item_ready), .item_i(item),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_found_o(found), .res_dist_o(distance), .res_x_o(x_end), .res_y_o(y_end)
  );

  assign m_axis_tdata = {7'd0, y_end, x_end, distance, found};

endmodule

// ===== src/mdea_ram.sv =====
// generic single-write single-read ram with registered read data
module mdea_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mdea_front.sv =====
// input side: accepts transactions, drops unknown kinds, two-entry queue
module mdea_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [1:0]                   s_tuser_i,
  input  logic [mdea_pkg::SymW-1:0]    s_tdata_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output mdea_pkg::item_t              item_o
);

  mdea_pkg::item_t entry_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            push, pop;
  mdea_pkg::op_e   op_in;

  assign op_in        = mdea_pkg::op_e'(s_tuser_i);
  assign s_tready_o   = (count_q != 2'd2);
  assign push         = s_tvalid_i && s_tready_o && (op_in != mdea_pkg::OP_NONE);
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = entry_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{op: op_in, sym: s_tdata_i};
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/mdea_back.sv =====
// execution side: sequence stores, diagonal search sequencer, result register
module mdea_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [5:0]                   cfg_data_i,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  mdea_pkg::item_t              item_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic                         res_found_o,
  output logic [mdea_pkg::DistW-1:0]   res_dist_o,
  output logic [8:0]                   res_x_o,
  output logic [8:0]                   res_y_o
);

  localparam int LenW  = mdea_pkg::LenW;
  localparam int DistW = mdea_pkg::DistW;
  localparam int XW    = mdea_pkg::XW;
  localparam int KW    = mdea_pkg::KW;
  localparam int YW    = mdea_pkg::YW;
  localparam int IdxW  = mdea_pkg::IdxW;
  localparam int AddrW = mdea_pkg::AddrW;

  mdea_pkg::state_e state_q, state_d;
  logic [2:0]           amode_q;
  logic [DistW-1:0]     maxd_q;
  logic [LenW-1:0]      len_a_q, len_a_d, len_b_q, len_b_d;
  mdea_pkg::amode_e     m_q, m_d;
  logic [DistW-1:0]     limit_q, limit_d, d_q, d_d;
  logic signed [KW-1:0] k_q, k_d;
  logic [XW-1:0]        x_q, x_d;
  logic [XW:0]          c0_q, c0_d, c1_q, c1_d;
  logic                 rf_q, rf_d;
  logic [DistW-1:0]     rd_q, rd_d;
  logic [8:0]           rx_q, rx_d, ry_q, ry_d;
  logic                 ov_q, ov_d, of_q, of_d;
  logic [DistW-1:0]     od_q, od_d;
  logic [8:0]           ox_q, ox_d, oy_q, oy_d;

  // ram ports
  logic                 we_a, we_b, row_we;
  logic [AddrW-1:0]     raddr_a, raddr_b;
  logic [3:0]           rdata_a, rdata_b;
  logic [IdxW:0]        row_raddr, row_waddr;
  logic [XW-1:0]        row_rdata;

  // derived search values
  logic signed [KW-1:0] dm, phi, plo, km1, kp1;
  logic signed [YW-1:0] y;
  logic                 v0, v1, v2, snake_ok, xe, ye, ends;
  logic [XW:0]          best, a0, a1, a2;
  logic                 bv;
  logic [DistW-1:0]     maxd_sat;
  logic [LenW:0]        len_sum;

  mdea_ram #(.Width(4), .Depth(mdea_pkg::MaxLen)) u_seq_a (
    .clk_i, .we_i(we_a), .waddr_i(len_a_q[AddrW-1:0]), .wdata_i(item_i.sym),
    .raddr_i(raddr_a), .rdata_o(rdata_a)
  );
  mdea_ram #(.Width(4), .Depth(mdea_pkg::MaxLen)) u_seq_b (
    .clk_i, .we_i(we_b), .waddr_i(len_b_q[AddrW-1:0]), .wdata_i(item_i.sym),
    .raddr_i(raddr_b), .rdata_o(rdata_b)
  );
  mdea_ram #(.Width(XW), .Depth(mdea_pkg::RowDepth)) u_rows (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(x_q),
    .raddr_i(row_raddr), .rdata_o(row_rdata)
  );

  // search geometry of the current row
  assign dm  = mdea_pkg::upper_diag(m_q, d_q);
  assign phi = (d_q == '0) ? -KW'(1) : mdea_pkg::upper_diag(m_q, d_q - DistW'(1));
  assign plo = KW'(1) - $signed(KW'(d_q));
  assign km1 = k_q - KW'(1);
  assign kp1 = k_q + KW'(1);
  assign v0  = (km1 >= plo) && (km1 <= phi);
  assign v1  = (k_q >= plo) && (k_q <= phi);
  assign v2  = (kp1 >= plo) && (kp1 <= phi);

  // end point tests
  assign y        = $signed({2'b00, x_q}) - YW'(k_q);
  assign snake_ok = (y >= 0) && ({1'b0, x_q} < (XW+1)'(len_b_q))
                    && (y < $signed(YW'(len_a_q)));
  assign xe = (x_q == XW'(len_b_q));
  assign ye = (y == $signed(YW'(len_a_q)));
  always_comb begin
    case (m_q)
      mdea_pkg::AM_A_PREFIX: ends = ye;
      mdea_pkg::AM_B_PREFIX, mdea_pkg::AM_PRIMER, mdea_pkg::AM_OVERLAP: ends = xe;
      mdea_pkg::AM_EITHER:   ends = xe || ye;
      default:               ends = xe && ye;
    endcase
  end

  // furthest reach from the previous row, or a free start on diagonal k in overlap mode
  assign a0 = c0_q + (XW+1)'(1);
  assign a1 = c1_q + (XW+1)'(1);
  assign a2 = {1'b0, row_rdata};
  always_comb begin
    best = '0;
    bv   = 1'b0;
    if (v0) begin
      best = a0;
      bv   = 1'b1;
    end
    if (v1 && (!bv || a1 > best)) begin
      best = a1;
      bv   = 1'b1;
    end
    if (v2 && (!bv || a2 > best)) begin
      best = a2;
      bv   = 1'b1;
    end
    if (m_q == mdea_pkg::AM_OVERLAP && k_q >= phi && k_q >= 0
        && (!bv || (XW+1)'(k_q) > best)) begin
      best = (XW+1)'(k_q);
    end
  end

  assign maxd_sat = (maxd_q > DistW'(mdea_pkg::MaxD)) ? DistW'(mdea_pkg::MaxD) : maxd_q;
  assign len_sum  = (LenW+1)'(len_a_q) + (LenW+1)'(len_b_q);

  assign raddr_a   = y[AddrW-1:0];
  assign raddr_b   = x_q[AddrW-1:0];
  assign row_waddr = {d_q[0], IdxW'(k_q + KW'(mdea_pkg::RowOff))};

  // sequencer
  always_comb begin
    state_d = state_q;
    len_a_d = len_a_q;
    len_b_d = len_b_q;
    m_d = m_q; limit_d = limit_q; d_d = d_q; k_d = k_q; x_d = x_q;
    c0_d = c0_q; c1_d = c1_q;
    rf_d = rf_q; rd_d = rd_q; rx_d = rx_q; ry_d = ry_q;
    ov_d = ov_q && !res_ready_i;
    of_d = of_q; od_d = od_q; ox_d = ox_q; oy_d = oy_q;
    we_a = 1'b0; we_b = 1'b0; row_we = 1'b0;
    item_ready_o = 1'b0;
    row_raddr = {~d_q[0], IdxW'(km1 + KW'(mdea_pkg::RowOff))};
    unique case (state_q)
      mdea_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          case (item_i.op)
            mdea_pkg::OP_LOAD_A: begin
              if (len_a_q < LenW'(mdea_pkg::MaxLen)) begin
                we_a    = 1'b1;
                len_a_d = len_a_q + LenW'(1);
              end
            end
            mdea_pkg::OP_LOAD_B: begin
              if (len_b_q < LenW'(mdea_pkg::MaxLen)) begin
                we_b    = 1'b1;
                len_b_d = len_b_q + LenW'(1);
              end
            end
            mdea_pkg::OP_START: begin
              limit_d = ((LenW+1)'(maxd_sat) > len_sum) ? DistW'(len_sum) : maxd_sat;
              m_d = (amode_q > 3'(mdea_pkg::AM_OVERLAP)) ? mdea_pkg::AM_EQUAL
                                                         : mdea_pkg::amode_e'(amode_q);
              d_d = '0;
              k_d = '0;
              rf_d = 1'b0; rd_d = limit_d; rx_d = '0; ry_d = '0;
              state_d = (limit_d == '0) ? mdea_pkg::ST_RES : mdea_pkg::ST_INIT_K;
            end
            default: ;
          endcase
        end
      end
      mdea_pkg::ST_INIT_K: begin
        if (d_q == '0) begin
          x_d     = XW'(k_q);
          state_d = mdea_pkg::ST_SN_RD;
        end else begin
          state_d = mdea_pkg::ST_RD0;
        end
      end
      mdea_pkg::ST_RD0: begin
        row_raddr = {~d_q[0], IdxW'(km1 + KW'(mdea_pkg::RowOff))};
        state_d   = mdea_pkg::ST_RD1;
      end
      mdea_pkg::ST_RD1: begin
        row_raddr = {~d_q[0], IdxW'(k_q + KW'(mdea_pkg::RowOff))};
        c0_d      = {1'b0, row_rdata};
        state_d   = mdea_pkg::ST_RD2;
      end
      mdea_pkg::ST_RD2: begin
        row_raddr = {~d_q[0], IdxW'(kp1 + KW'(mdea_pkg::RowOff))};
        c1_d      = {1'b0, row_rdata};
        state_d   = mdea_pkg::ST_RD3;
      end
      mdea_pkg::ST_RD3: begin
        x_d     = best[XW-1:0];
        state_d = mdea_pkg::ST_SN_RD;
      end
      mdea_pkg::ST_SN_RD: begin
        state_d = snake_ok ? mdea_pkg::ST_SN_CMP : mdea_pkg::ST_END;
      end
      mdea_pkg::ST_SN_CMP: begin
        if ((rdata_a & rdata_b) != 4'd0) begin
          x_d     = x_q + XW'(1);
          state_d = mdea_pkg::ST_SN_RD;
        end else begin
          state_d = mdea_pkg::ST_END;
        end
      end
      mdea_pkg::ST_END: begin
        row_we = 1'b1;
        if (ends) begin
          rf_d = 1'b1; rd_d = d_q; rx_d = x_q[8:0]; ry_d = y[8:0];
          state_d = mdea_pkg::ST_RES;
        end else if (k_q == dm) begin
          if (d_q + DistW'(1) == limit_q) begin
            state_d = mdea_pkg::ST_RES;
          end else begin
            d_d     = d_q + DistW'(1);
            k_d     = -$signed(KW'(d_d));
            state_d = mdea_pkg::ST_INIT_K;
          end
        end else begin
          k_d     = kp1;
          state_d = mdea_pkg::ST_INIT_K;
        end
      end
      mdea_pkg::ST_RES: begin
        if (!ov_q || res_ready_i) begin
          ov_d = 1'b1; of_d = rf_q; od_d = rd_q; ox_d = rx_q; oy_d = ry_q;
          len_a_d = '0;
          len_b_d = '0;
          state_d = mdea_pkg::ST_IDLE;
        end
      end
      default: state_d = mdea_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdea_pkg::ST_IDLE;
      len_a_q <= '0;
      len_b_q <= '0;
      ov_q    <= 1'b0;
      amode_q <= 3'(mdea_pkg::AM_EQUAL);
      maxd_q  <= DistW'(mdea_pkg::MaxD);
    end else begin
      state_q <= state_d;
      len_a_q <= len_a_d;
      len_b_q <= len_b_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (mdea_pkg::reg_e'(cfg_idx_i))
          mdea_pkg::REG_ALIGN_MODE: amode_q <= cfg_data_i[2:0];
          default:                  maxd_q  <= cfg_data_i;
        endcase
      end
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    m_q <= m_d; limit_q <= limit_d; d_q <= d_d; k_q <= k_d; x_q <= x_d;
    c0_q <= c0_d; c1_q <= c1_d;
    rf_q <= rf_d; rd_q <= rd_d; rx_q <= rx_d; ry_q <= ry_d;
    of_q <= of_d; od_q <= od_d; ox_q <= ox_d; oy_q <= oy_d;
  end

  assign res_valid_o = ov_q;
  assign res_found_o = of_q;
  assign res_dist_o  = od_q;
  assign res_x_o     = ox_q;
  assign res_y_o     = oy_q;

endmodule
